>>> hdl/csp_pkg.sv
`timescale 1ns / 1ps

package csp_pkg;

    localparam int unsigned CountW   = 4;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned NibW     = 32;
    localparam int unsigned StatusW  = 3;

    localparam logic [CountW-1:0] MaxCount = CountW'(10);

    localparam logic [StatusW-1:0] ST_OK        = 3'd0;
    localparam logic [StatusW-1:0] ST_BAD_LETTER = 3'd1;
    localparam logic [StatusW-1:0] ST_BAD_COUNT  = 3'd2;
    localparam logic [StatusW-1:0] ST_BAD_DIGIT  = 3'd3;
    localparam logic [StatusW-1:0] ST_NAMED      = 3'd4;

    localparam logic [ByteW-1:0] CH_HASH = 8'h23;

    localparam logic [7:0] FULL  = 8'd255;
    localparam logic [7:0] DARK  = 8'd150;
    localparam logic [7:0] LIGHT = 8'd200;
    localparam logic [7:0] SLATE = 8'd100;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic [ByteW-1:0]  first;
        logic [NibW-1:0]   nibbles;
        logic              bad;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [StatusW-1:0] status;
    } color_t;

    // Bit 4 set means not a hex digit.
    function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 5'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 5'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 5'(c - 8'h37);
        end
        return v;
    endfunction

    function automatic color_t letter_color(input logic [ByteW-1:0] c);
        color_t r;
        r = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: FULL, status: ST_OK};
        case (c)
            8'h62: r.blue = FULL;                                       // b
            8'h67: r.green = FULL;                                      // g
            8'h72: r.red = FULL;                                        // r
            8'h63: begin r.green = FULL; r.blue = FULL; end             // c
            8'h6d: begin r.red = FULL; r.blue = FULL; end               // m
            8'h79: begin r.red = FULL; r.green = FULL; end              // y
            8'h6b: ;                                                    // k
            8'h77: begin r.red = FULL; r.green = FULL; r.blue = FULL; end
            8'h64: begin r.red = DARK; r.green = DARK; r.blue = DARK; end
            8'h6c: begin r.red = LIGHT; r.green = LIGHT; r.blue = LIGHT; end
            8'h73: begin r.red = SLATE; r.green = SLATE; r.blue = DARK; end
            default:
            begin
                r.alpha  = 8'd0;
                r.status = ST_BAD_LETTER;
            end
        endcase
        return r;
    endfunction

endpackage

>>> hdl/color_string_parser.sv
`timescale 1ns / 1ps

// Color string parser.
// Input channel (in_valid/in_ready): one string byte per item on char_code,
// last_char high on the final byte. Output channel (out_valid/out_ready):
// one RGBA item plus status for each string, given after its last byte.
// Single lower-case letters come from a fixed table; other single bytes
// get a bad-letter status. '#' with 3, 4, 6 or 8 hex digits gives the
// color, other counts below nine a bad-count status, a non-hex digit a
// bad-digit status; longer '#' strings and the rest a named-lookup status.
// Throughput: one byte per cycle unless stalled. Bytes pass the input
// register, then update the running state; a final byte puts the color in
// the output register and sets out_valid. If the receiver stalls, the
// result holds there and non-final bytes of the next string keep flowing;
// only a final byte waits for the output register to free up, and in_ready
// then drops. Reset clears the running state and both valid flags.
module color_string_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic [7:0] alpha,
    output logic [2:0] status
);
    import csp_pkg::*;

    logic         s1_valid_reg;
    logic [7:0]   s1_char_reg;
    logic         s1_last_reg;
    logic         out_valid_reg;
    color_t       res_reg;

    logic         out_free;
    logic         s1_fire;
    parse_state_t state_next;
    color_t       color;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= last_char;
        end
    end

    csp_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_fire),
        .char_code  (s1_char_reg),
        .last_char  (s1_last_reg),
        .state_next (state_next)
    );

    csp_decode u_decode (
        .st    (state_next),
        .color (color)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            res_reg <= color;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = res_reg.red;
    assign green     = res_reg.green;
    assign blue      = res_reg.blue;
    assign alpha     = res_reg.alpha;
    assign status    = res_reg.status;

`ifndef SYNTH
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> out_valid_reg)
        else $error("last byte did not produce a result");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.status != ST_OK |->
            res_reg.red == 8'd0 && res_reg.green == 8'd0 &&
            res_reg.blue == 8'd0 && res_reg.alpha == 8'd0)
        else $error("nonzero channels on error result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(s1_fire && s1_last_reg))
        else $error("pending result overwritten");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.status <= ST_NAMED)
        else $error("status code out of range");
`endif

endmodule

>>> hdl/csp_accum.sv
`timescale 1ns / 1ps

module csp_accum (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              char_code,
    input  logic                    last_char,
    output csp_pkg::parse_state_t   state_next
);
    import csp_pkg::*;

    parse_state_t state_reg;
    logic [4:0]   hv;

    always_comb
    begin
        hv         = hex_value(char_code);
        state_next = state_reg;
        if (state_reg.count == '0)
        begin
            state_next.first = char_code;
        end
        else if (hv[4])
        begin
            state_next.bad = 1'b1;
        end
        else
        begin
            state_next.nibbles = {state_reg.nibbles[NibW-5:0], hv[3:0]};
        end
        if (state_reg.count < MaxCount)
        begin
            state_next.count = state_reg.count + CountW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step)
        begin
            // string done: start fresh for the next one
            state_reg <= last_char ? '0 : state_next;
        end
    end

`ifndef SYNTH
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count <= MaxCount)
        else $error("char count past saturation");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_char |=> state_reg == '0)
        else $error("state not cleared after last byte");

    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last_char && state_reg.count == '0 |=> state_reg.first == $past(char_code))
        else $error("first byte not captured");
`endif

endmodule

>>> hdl/csp_decode.sv
`timescale 1ns / 1ps

module csp_decode (
    input  csp_pkg::parse_state_t   st,
    output csp_pkg::color_t         color
);
    import csp_pkg::*;

    logic [CountW-1:0] digits;
    logic [NibW-1:0]   s;

    always_comb
    begin
        s      = st.nibbles;
        digits = st.count - CountW'(1);
        color  = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0, status: ST_OK};
        if (st.count == CountW'(1))
        begin
            color = letter_color(st.first);
        end
        else if (st.first == CH_HASH && st.count < MaxCount)
        begin
            if (digits != CountW'(3) && digits != CountW'(4) &&
                digits != CountW'(6) && digits != CountW'(8))
            begin
                color.status = ST_BAD_COUNT;
            end
            else if (st.bad)
            begin
                color.status = ST_BAD_DIGIT;
            end
            else if (digits == CountW'(3))
            begin
                // short forms: nibble times 17 is the nibble doubled
                color.red   = {s[11:8], s[11:8]};
                color.green = {s[7:4], s[7:4]};
                color.blue  = {s[3:0], s[3:0]};
                color.alpha = FULL;
            end
            else if (digits == CountW'(4))
            begin
                color.red   = {s[15:12], s[15:12]};
                color.green = {s[11:8], s[11:8]};
                color.blue  = {s[7:4], s[7:4]};
                color.alpha = {s[3:0], s[3:0]};
            end
            else if (digits == CountW'(6))
            begin
                color.red   = s[23:16];
                color.green = s[15:8];
                color.blue  = s[7:0];
                color.alpha = FULL;
            end
            else
            begin
                color.red   = s[31:24];
                color.green = s[23:16];
                color.blue  = s[15:8];
                color.alpha = s[7:0];
            end
        end
        else
        begin
            color.status = ST_NAMED;
        end
    end

endmodule
